### sv/ppls_pkg.sv
// package: widths, latencies, item types and register indexes of the phong shading unit
package ppls_pkg;

    localparam int POS_W      = 32;
    localparam int COL_W      = 16;
    localparam int NRM_W      = 16;
    localparam int DIF_W      = POS_W + 1;
    localparam int Q15        = 15;
    localparam int VEC_W      = 40;
    localparam int MAG_W      = 31;
    localparam int SH_W       = 4;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = 64;
    localparam int LEN_W      = 32;
    localparam int REM_W      = 48;
    localparam int Q_W        = 16;
    localparam int UNIT_W     = Q_W + 1;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int UNIT_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;

    localparam int TN_W = DIF_W + NRM_W;
    localparam int KS_W = TN_W + 2;
    localparam int K_W  = KS_W - Q15;
    localparam int P_W  = K_W + 1 + NRM_W;
    localparam int PD_W = NRM_W + UNIT_W;
    localparam int PS_W = 2 * UNIT_W;
    localparam int DS_W = PS_W + 2;
    localparam int FD_W = 17;
    localparam int SP_W = 16;
    localparam int CD_W = COL_W + FD_W;
    localparam int CS_W = COL_W + SP_W;

    localparam int SQ_STEPS = 8;
    localparam int NRM_DLY  = 4 + UNIT_LAT;
    localparam int COL_DLY  = NRM_DLY + 2 + SQ_STEPS;
    localparam int BACK_LAT = COL_DLY + 2;

    localparam logic [SP_W-1:0]  ONE_Q15 = SP_W'(32768);
    localparam logic [COL_W-1:0] SAT16   = '1;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X,
        CFG_CAMERA_Y,
        CFG_CAMERA_Z
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0][DIF_W-1:0] d;
        logic [2:0][DIF_W-1:0] v;
        logic [2:0][NRM_W-1:0] nrm;
        logic [2:0][COL_W-1:0] col;
    } t_item;

    typedef struct packed {
        logic [2:0][COL_W-1:0] diffuse;
        logic [2:0][COL_W-1:0] specular;
    } t_result;

endpackage

### sv/ppls_front.sv
// front end: camera registers, item intake and light and view difference vectors
module ppls_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0][ppls_pkg::POS_W-1:0]      i_light,
    input  logic [2:0][ppls_pkg::COL_W-1:0]      i_color,
    input  logic [2:0][ppls_pkg::POS_W-1:0]      i_point,
    input  logic [2:0][ppls_pkg::NRM_W-1:0]      i_normal,
    input  logic                                 i_cfg_wr_en,
    input  logic [ppls_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppls_pkg::POS_W-1:0]           i_cfg_data,
    input  logic                                 i_full,
    output logic                                 o_push,
    output ppls_pkg::t_item                      o_item
);
    import ppls_pkg::*;

    logic [2:0][POS_W-1:0] r_cam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CAMERA_X: r_cam[0] <= i_cfg_data;
                CFG_CAMERA_Y: r_cam[1] <= i_cfg_data;
                CFG_CAMERA_Z: r_cam[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_item.d[c] = DIF_W'($signed(i_light[c])) - DIF_W'($signed(i_point[c]));
            o_item.v[c] = DIF_W'($signed(r_cam[c])) - DIF_W'($signed(i_point[c]));
        end
        o_item.nrm = i_normal;
        o_item.col = i_color;
    end

endmodule

### sv/ppls_queue.sv
// short item queue between the front end and the shading pipeline
module ppls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppls_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ppls_pkg::t_item o_item
);
    import ppls_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != CNT_W'(QDEPTH))
        else $error("push into full queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count did not follow push");

endmodule

### sv/ppls_unit.sv
// pipelined vector normalizer: shift, sum of squares, square root, per-component divide
module ppls_unit (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [2:0][ppls_pkg::VEC_W-1:0]    i_vec,
    output logic [2:0][ppls_pkg::UNIT_W-1:0]   o_unit,
    output logic                               o_nonzero
);
    import ppls_pkg::*;

    logic [2:0][VEC_W-1:0]  r_mag1;
    logic [2:0]             r_sg1;
    logic [VEC_W-1:0]       w_or;
    logic [SH_W-1:0]        w_sh;
    logic [2:0][MAG_W-1:0]  r_m2;
    logic [2:0]             r_sg2;
    logic [2:0][SQ_W-1:0]   r_sq3;
    logic [2:0][MAG_W-1:0]  r_m3;
    logic [2:0]             r_sg3;

    logic [SUM_W-1:0]       r_sx [SQRT_STEPS+1];
    logic [SUM_W-1:0]       r_sr [SQRT_STEPS+1];
    logic [2:0][MAG_W-1:0]  r_sm [SQRT_STEPS+1];
    logic [2:0]             r_ss [SQRT_STEPS+1];
    logic                   r_sz [SQRT_STEPS+1];

    logic [2:0][REM_W-1:0]  r_dr [DIV_STEPS];
    logic [2:0][Q_W-1:0]    r_dq [DIV_STEPS];
    logic [LEN_W-1:0]       r_dl [DIV_STEPS];
    logic [2:0]             r_ds [DIV_STEPS];
    logic                   r_dz [DIV_STEPS];

    logic [2:0][UNIT_W-1:0] r_unit;
    logic                   r_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sg1[c]  <= i_vec[c][VEC_W-1];
                r_mag1[c] <= i_vec[c][VEC_W-1] ? (~i_vec[c] + VEC_W'(1)) : i_vec[c];
            end
        end
    end

    always_comb begin
        w_or = r_mag1[0] | r_mag1[1] | r_mag1[2];
        w_sh = '0;
        for (int h = MAG_W; h < VEC_W; h++) begin
            if (w_or[h]) begin
                w_sh = SH_W'(h - (MAG_W - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_m2[c]  <= MAG_W'(r_mag1[c] >> w_sh);
                r_sq3[c] <= SQ_W'(r_m2[c]) * SQ_W'(r_m2[c]);
            end
            r_sg2   <= r_sg1;
            r_m3    <= r_m2;
            r_sg3   <= r_sg2;
            r_sx[0] <= SUM_W'(r_sq3[0]) + SUM_W'(r_sq3[1]) + SUM_W'(r_sq3[2]);
            r_sr[0] <= '0;
            r_sm[0] <= r_m3;
            r_ss[0] <= r_sg3;
            r_sz[0] <= (r_m3 == '0);
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * j);
        logic [SUM_W-1:0] w_try;
        assign w_try = r_sr[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sx[j] >= w_try) begin
                    r_sx[j+1] <= r_sx[j] - w_try;
                    r_sr[j+1] <= (r_sr[j] >> 1) + BIT;
                end else begin
                    r_sx[j+1] <= r_sx[j];
                    r_sr[j+1] <= r_sr[j] >> 1;
                end
                r_sm[j+1] <= r_sm[j];
                r_ss[j+1] <= r_ss[j];
                r_sz[j+1] <= r_sz[j];
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [2:0][REM_W-1:0] w_rem;
        logic [2:0][Q_W-1:0]   w_q;
        logic [LEN_W-1:0]      w_len;
        logic [2:0]            w_sg;
        logic                  w_z;
        logic [REM_W-1:0]      w_den;
        if (j == 0) begin : g_first
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    w_rem[c] = REM_W'(r_sm[SQRT_STEPS][c]) << Q15;
                end
                w_q   = '0;
                w_len = r_sr[SQRT_STEPS][LEN_W-1:0];
                w_sg  = r_ss[SQRT_STEPS];
                w_z   = r_sz[SQRT_STEPS];
            end
        end else begin : g_next
            always_comb begin
                w_rem = r_dr[j-1];
                w_q   = r_dq[j-1];
                w_len = r_dl[j-1];
                w_sg  = r_ds[j-1];
                w_z   = r_dz[j-1];
            end
        end
        assign w_den = REM_W'(w_len) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    if (w_rem[c] >= w_den) begin
                        r_dr[j][c] <= w_rem[c] - w_den;
                        r_dq[j][c] <= w_q[c] | (Q_W'(1) << B);
                    end else begin
                        r_dr[j][c] <= w_rem[c];
                        r_dq[j][c] <= w_q[c];
                    end
                end
                r_dl[j] <= w_len;
                r_ds[j] <= w_sg;
                r_dz[j] <= w_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_dz[DIV_STEPS-1]) begin
                    r_unit[c] <= '0;
                end else if (r_ds[DIV_STEPS-1][c]) begin
                    r_unit[c] <= UNIT_W'(0) - UNIT_W'(r_dq[DIV_STEPS-1][c]);
                end else begin
                    r_unit[c] <= UNIT_W'(r_dq[DIV_STEPS-1][c]);
                end
            end
            r_nz <= !r_dz[DIV_STEPS-1];
        end
    end

    assign o_unit    = r_unit;
    assign o_nonzero = r_nz;

endmodule

### sv/ppls_back.sv
// shading pipeline: reflection, three normalizers, dot products, power and color scaling
module ppls_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ppls_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ppls_pkg::t_result o_result
);
    import ppls_pkg::*;

    logic                    w_en;
    logic [BACK_LAT-1:0]     r_vld;

    logic [2:0][NRM_W-1:0]   r_nrm [NRM_DLY];
    logic [2:0][COL_W-1:0]   r_col [COL_DLY];

    logic [2:0][DIF_W-1:0]   w_t;
    logic [2:0][DIF_W-1:0]   r_t1, r_t2, r_t3;
    logic [2:0][DIF_W-1:0]   r_d1, r_d2, r_d3;
    logic [2:0][DIF_W-1:0]   r_v1, r_v2, r_v3;
    logic [2:0][TN_W-1:0]    r_tn1;
    logic signed [KS_W-1:0]  w_ksum;
    logic [K_W-1:0]          r_k2;
    logic [2:0][P_W-1:0]     r_p3;
    logic [2:0][VEC_W-1:0]   r_r4, r_d4, r_v4;

    logic [2:0][UNIT_W-1:0]  w_ul, w_uv, w_ur;
    logic                    w_nzl, w_nzv, w_nzr;

    logic [2:0][PD_W-1:0]    r_pd;
    logic [2:0][PS_W-1:0]    r_ps;
    logic                    r_nzd, r_nzs;
    logic signed [DS_W-1:0]  w_sd, w_ss;
    logic [FD_W-1:0]         w_fd;
    logic [FD_W-1:0]         w_s17;
    logic [SP_W-1:0]         w_fs;

    logic [FD_W-1:0]         r_fd [SQ_STEPS+1];
    logic [SP_W-1:0]         r_sp [SQ_STEPS+1];
    logic [2*SP_W-1:0]       w_sqp [SQ_STEPS];

    logic [2:0][CD_W-1:0]    r_cd;
    logic [2:0][CS_W-1:0]    r_cs;
    logic [2:0][CD_W-Q15-1:0] w_dd;
    logic [2:0][CS_W-Q15-1:0] w_sc;
    t_result                 r_out;

    assign w_en    = !r_vld[BACK_LAT-1] || i_ready;
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_vld[BACK_LAT-1];
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nrm[0] <= i_item.nrm;
            for (int k = 1; k < NRM_DLY; k++) begin
                r_nrm[k] <= r_nrm[k-1];
            end
            r_col[0] <= i_item.col;
            for (int k = 1; k < COL_DLY; k++) begin
                r_col[k] <= r_col[k-1];
            end
        end
    end

    // reflection of the light-to-point vector about the normal
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_t[c] = DIF_W'(0) - i_item.d[c];
        end
        w_ksum = KS_W'($signed(r_tn1[0])) + KS_W'($signed(r_tn1[1]))
               + KS_W'($signed(r_tn1[2]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_tn1[c] <= $signed(w_t[c]) * $signed(i_item.nrm[c]);
                r_p3[c]  <= $signed({r_k2, 1'b0}) * $signed(r_nrm[1][c]);
                r_r4[c]  <= VEC_W'($signed(r_t3[c])) - VEC_W'($signed(r_p3[c][P_W-1:Q15]));
                r_d4[c]  <= VEC_W'($signed(r_d3[c]));
                r_v4[c]  <= VEC_W'($signed(r_v3[c]));
            end
            r_t1 <= w_t;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_d1 <= i_item.d;
            r_d2 <= r_d1;
            r_d3 <= r_d2;
            r_v1 <= i_item.v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_k2 <= w_ksum[KS_W-1:Q15];
        end
    end

    ppls_unit u_light (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_vec     (r_d4),
        .o_unit    (w_ul),
        .o_nonzero (w_nzl)
    );

    ppls_unit u_view (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_vec     (r_v4),
        .o_unit    (w_uv),
        .o_nonzero (w_nzv)
    );

    ppls_unit u_refl (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_vec     (r_r4),
        .o_unit    (w_ur),
        .o_nonzero (w_nzr)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_pd[c] <= $signed(r_nrm[NRM_DLY-1][c]) * $signed(w_ul[c]);
                r_ps[c] <= $signed(w_uv[c]) * $signed(w_ur[c]);
            end
            r_nzd <= w_nzl;
            r_nzs <= w_nzv && w_nzr;
        end
    end

    always_comb begin
        w_sd  = DS_W'($signed(r_pd[0])) + DS_W'($signed(r_pd[1])) + DS_W'($signed(r_pd[2]));
        w_ss  = DS_W'($signed(r_ps[0])) + DS_W'($signed(r_ps[1])) + DS_W'($signed(r_ps[2]));
        w_s17 = w_ss[FD_W+Q15-1:Q15];
        if (!r_nzd || w_sd <= 0) begin
            w_fd = '0;
        end else begin
            w_fd = w_sd[FD_W+Q15-1:Q15];
        end
        if (!r_nzs || w_ss <= 0) begin
            w_fs = '0;
        end else if (w_s17 > FD_W'(ONE_Q15)) begin
            w_fs = ONE_Q15;
        end else begin
            w_fs = w_s17[SP_W-1:0];
        end
        for (int j = 0; j < SQ_STEPS; j++) begin
            w_sqp[j] = (2*SP_W)'(r_sp[j]) * (2*SP_W)'(r_sp[j]);
        end
    end

    // shininess 256 as eight squarings
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd[0] <= w_fd;
            r_sp[0] <= w_fs;
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_fd[j+1] <= r_fd[j];
                r_sp[j+1] <= w_sqp[j][SP_W+Q15-1:Q15];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_dd[c] = r_cd[c][CD_W-1:Q15];
            w_sc[c] = r_cs[c][CS_W-1:Q15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_cd[c] <= CD_W'(r_col[COL_DLY-1][c]) * CD_W'(r_fd[SQ_STEPS]);
                r_cs[c] <= CS_W'(r_col[COL_DLY-1][c]) * CS_W'(r_sp[SQ_STEPS] >> 1);
                r_out.diffuse[c]  <= (w_dd[c] > (CD_W-Q15)'(SAT16)) ? SAT16
                                                                    : w_dd[c][COL_W-1:0];
                r_out.specular[c] <= (w_sc[c] > (CS_W-Q15)'(SAT16)) ? SAT16
                                                                    : w_sc[c][COL_W-1:0];
            end
        end
    end

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0])
        else $error("popped item not in first stage");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_vld[BACK_LAT-2]) |=> !o_valid)
        else $error("result without item behind it");

endmodule

### sv/phong_point_light_shading_unit.sv
// top level: phong diffuse and specular shading of one point light per item
//
//  channel   signals                                   direction  width
//  request   i_valid / o_ready, light/point/normal     in         32/16 per field
//  result    o_valid / i_ready, diffuse/specular rgb   out        16 per field
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_data      in         2-bit index, 32-bit data
//
//  one item per cycle while the result is not stalled; the normalizers use
//  a square root of 32 steps and a divide of 16 steps
//  a four-entry queue sits between intake and the pipeline
//  a stalled result freezes the whole pipeline; intake continues until the queue fills
//  reset clears the camera registers, queue pointers and pipeline valid bits
module phong_point_light_shading_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ppls_pkg::POS_W-1:0]        i_light_x,
    input  logic [ppls_pkg::POS_W-1:0]        i_light_y,
    input  logic [ppls_pkg::POS_W-1:0]        i_light_z,
    input  logic [ppls_pkg::COL_W-1:0]        i_light_red,
    input  logic [ppls_pkg::COL_W-1:0]        i_light_green,
    input  logic [ppls_pkg::COL_W-1:0]        i_light_blue,
    input  logic [ppls_pkg::POS_W-1:0]        i_point_x,
    input  logic [ppls_pkg::POS_W-1:0]        i_point_y,
    input  logic [ppls_pkg::POS_W-1:0]        i_point_z,
    input  logic [ppls_pkg::NRM_W-1:0]        i_normal_x,
    input  logic [ppls_pkg::NRM_W-1:0]        i_normal_y,
    input  logic [ppls_pkg::NRM_W-1:0]        i_normal_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ppls_pkg::COL_W-1:0]        o_diffuse_red,
    output logic [ppls_pkg::COL_W-1:0]        o_diffuse_green,
    output logic [ppls_pkg::COL_W-1:0]        o_diffuse_blue,
    output logic [ppls_pkg::COL_W-1:0]        o_specular_red,
    output logic [ppls_pkg::COL_W-1:0]        o_specular_green,
    output logic [ppls_pkg::COL_W-1:0]        o_specular_blue,
    input  logic                              i_cfg_wr_en,
    input  logic [ppls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppls_pkg::POS_W-1:0]        i_cfg_data
);
    import ppls_pkg::*;

    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_qvalid;
    t_item   w_fitem;
    t_item   w_qitem;
    t_result w_res;

    ppls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_light     ({i_light_z, i_light_y, i_light_x}),
        .i_color     ({i_light_blue, i_light_green, i_light_red}),
        .i_point     ({i_point_z, i_point_y, i_point_x}),
        .i_normal    ({i_normal_z, i_normal_y, i_normal_x}),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_fitem)
    );

    ppls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_item  (w_qitem)
    );

    ppls_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_item   (w_qitem),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_res)
    );

    assign o_diffuse_red    = w_res.diffuse[0];
    assign o_diffuse_green  = w_res.diffuse[1];
    assign o_diffuse_blue   = w_res.diffuse[2];
    assign o_specular_red   = w_res.specular[0];
    assign o_specular_green = w_res.specular[1];
    assign o_specular_blue  = w_res.specular[2];

endmodule

### dv/phong_point_light_shading_unit_tb.sv
// testbench for the phong point-light shading unit: random and directed items against a built-in predictor
module phong_point_light_shading_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppls_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = UNIT_LAT + 40;

    typedef longint vec3_t [3];

    typedef struct {
        logic [POS_W-1:0] lx, ly, lz;
        logic [COL_W-1:0] cr, cg, cb;
        logic [POS_W-1:0] px, py, pz;
        logic [NRM_W-1:0] nx, ny, nz;
    } hit_t;

    typedef struct {
        logic [COL_W-1:0] dr, dg, db, sr, sg, sb;
    } shade_t;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_ready, o_valid, i_ready = 0;
    logic [POS_W-1:0] i_light_x = 0, i_light_y = 0, i_light_z = 0;
    logic [COL_W-1:0] i_light_red = 0, i_light_green = 0, i_light_blue = 0;
    logic [POS_W-1:0] i_point_x = 0, i_point_y = 0, i_point_z = 0;
    logic [NRM_W-1:0] i_normal_x = 0, i_normal_y = 0, i_normal_z = 0;
    logic [COL_W-1:0] o_diffuse_red, o_diffuse_green, o_diffuse_blue;
    logic [COL_W-1:0] o_specular_red, o_specular_green, o_specular_blue;
    logic i_cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [POS_W-1:0] i_cfg_data = 0;

    phong_point_light_shading_unit uut (.*);

    always #5 i_clk = ~i_clk;

    hit_t   pending_hits[$];
    shade_t expected_shades[$];
    hit_t   cur_hit;
    longint camera[3] = '{0, 0, 0};
    bit     in_fire = 0, out_fire = 0;
    bit     idle_on = 1;
    bit     long_hold_req = 0;
    int     send_gap = 0, hold_left = 0;
    int     mismatches = 0, accepted = 0, results = 0, spec_hits = 0;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r = 0, b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit to_unit(input vec3_t v, output vec3_t u);
        longint unsigned m[3];
        longint unsigned sum = 0, len;
        int s = 0;
        for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
        while (s < 63 && ((m[0] >> s) | (m[1] >> s) | (m[2] >> s)) >= 64'h8000_0000) s++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= s;
            sum += m[i] * m[i];
        end
        len = isqrt(sum);
        u = '{0, 0, 0};
        if (len == 0) return 0;
        for (int i = 0; i < 3; i++) begin
            longint q;
            q = longint'((m[i] << 15) / len);
            u[i] = (v[i] < 0) ? -q : q;
        end
        return 1;
    endfunction

    function automatic longint unsigned cos_q15(input vec3_t a, input vec3_t b);
        longint d;
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        return (d <= 0) ? 0 : longint'(d >>> 15);
    endfunction

    function automatic logic [COL_W-1:0] tint(logic [COL_W-1:0] c, longint unsigned f);
        longint unsigned r;
        r = (longint'(c) * f) >> 15;
        return (r > 65535) ? SAT16 : r[COL_W-1:0];
    endfunction

    function automatic shade_t shade_hit(hit_t h);
        vec3_t lp, pp, n, d, t, r, v, ul, ur, uv;
        longint k;
        longint unsigned fd = 0, fs = 0, s;
        shade_t o;
        lp = '{longint'($signed(h.lx)), longint'($signed(h.ly)), longint'($signed(h.lz))};
        pp = '{longint'($signed(h.px)), longint'($signed(h.py)), longint'($signed(h.pz))};
        n  = '{longint'($signed(h.nx)), longint'($signed(h.ny)), longint'($signed(h.nz))};
        for (int i = 0; i < 3; i++) begin
            d[i] = lp[i] - pp[i];
            t[i] = pp[i] - lp[i];
            v[i] = camera[i] - pp[i];
        end
        if (to_unit(d, ul)) fd = cos_q15(n, ul);
        k = (t[0] * n[0] + t[1] * n[1] + t[2] * n[2]) >>> 15;
        for (int i = 0; i < 3; i++) r[i] = t[i] - ((2 * k * n[i]) >>> 15);
        if (to_unit(v, uv) && to_unit(r, ur)) begin
            s = cos_q15(uv, ur);
            if (s > 32768) s = 32768;
            for (int i = 0; i < SQ_STEPS; i++) s = (s * s) >> 15;
            fs = s >> 1;
        end
        o.dr = tint(h.cr, fd);
        o.dg = tint(h.cg, fd);
        o.db = tint(h.cb, fd);
        o.sr = tint(h.cr, fs);
        o.sg = tint(h.cg, fs);
        o.sb = tint(h.cb, fs);
        return o;
    endfunction

    function automatic void check_field(string name, logic [COL_W-1:0] exp_v,
                                        logic [COL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         results, name, exp_v, act_v);
        end
    endfunction

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 17) : 0;
    endfunction

    // acceptance, prediction and result checking
    always @(posedge i_clk) begin
        shade_t e;
        in_fire  = i_rst_n && i_valid && o_ready;
        out_fire = i_rst_n && o_valid && i_ready;
        if (in_fire) begin
            expected_shades.push_back(shade_hit(cur_hit));
            accepted++;
        end
        if (out_fire) begin
            if (expected_shades.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result %0d with no item outstanding", results);
            end else begin
                e = expected_shades.pop_front();
                if (e.sr != 0 || e.sg != 0 || e.sb != 0) spec_hits++;
                check_field("diffuse_red", e.dr, o_diffuse_red);
                check_field("diffuse_green", e.dg, o_diffuse_green);
                check_field("diffuse_blue", e.db, o_diffuse_blue);
                check_field("specular_red", e.sr, o_specular_red);
                check_field("specular_green", e.sg, o_specular_green);
                check_field("specular_blue", e.sb, o_specular_blue);
            end
            results++;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        logic v;
        v = i_valid;
        if (in_fire) v = 0;
        if (!v && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_hits.size() != 0) begin
                cur_hit = pending_hits.pop_front();
                i_light_x <= cur_hit.lx;
                i_light_y <= cur_hit.ly;
                i_light_z <= cur_hit.lz;
                i_light_red <= cur_hit.cr;
                i_light_green <= cur_hit.cg;
                i_light_blue <= cur_hit.cb;
                i_point_x <= cur_hit.px;
                i_point_y <= cur_hit.py;
                i_point_z <= cur_hit.pz;
                i_normal_x <= cur_hit.nx;
                i_normal_y <= cur_hit.ny;
                i_normal_z <= cur_hit.nz;
                v = 1;
                send_gap = draw_wait();
            end
        end
        i_valid <= v;
    end

    // result receiver
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left = 400;
            long_hold_req = 0;
        end else if (out_fire && hold_left == 0) begin
            hold_left = draw_wait();
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 0;
        end else begin
            i_ready <= i_rst_n;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= value[POS_W-1:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        if (idx != CFG_SPARE) camera[idx] = longint'($signed(value[POS_W-1:0]));
    endtask

    task automatic set_camera(longint cx, longint cy, longint cz);
        write_reg(CFG_CAMERA_X, cx);
        write_reg(CFG_CAMERA_Y, cy);
        write_reg(CFG_CAMERA_Z, cz);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_hits.size() != 0 || i_valid || expected_shades.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] near_pos(int span);
        return POS_W'(longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic hit_t make_hit(logic [POS_W-1:0] lx, logic [POS_W-1:0] ly,
                                      logic [POS_W-1:0] lz, logic [POS_W-1:0] px,
                                      logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                                      logic [NRM_W-1:0] nx, logic [NRM_W-1:0] ny,
                                      logic [NRM_W-1:0] nz, logic [COL_W-1:0] c);
        hit_t h;
        h.lx = lx; h.ly = ly; h.lz = lz;
        h.px = px; h.py = py; h.pz = pz;
        h.nx = nx; h.ny = ny; h.nz = nz;
        h.cr = c; h.cg = ~c; h.cb = c ^ 16'h5a5a;
        return h;
    endfunction

    function automatic hit_t random_hit();
        hit_t h;
        if ($urandom_range(0, 3) == 0) begin
            h = make_hit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         NRM_W'($urandom), NRM_W'($urandom), NRM_W'($urandom),
                         COL_W'($urandom));
        end else if ($urandom_range(0, 1) == 0) begin
            // light mirrored from the camera about a +z normal, so the highlight shows
            h.px = near_pos(1 << 18);
            h.py = near_pos(1 << 18);
            h.pz = near_pos(1 << 14);
            h.lx = POS_W'(2 * longint'($signed(h.px)) - camera[0] + $signed(near_pos(300)));
            h.ly = POS_W'(2 * longint'($signed(h.py)) - camera[1] + $signed(near_pos(300)));
            h.lz = POS_W'(camera[2] + $signed(near_pos(300)));
            h.nx = NRM_W'(near_pos(150));
            h.ny = NRM_W'(near_pos(150));
            h.nz = NRM_W'(32767 - $urandom_range(0, 100));
        end else begin
            h = make_hit(near_pos(1 << 21), near_pos(1 << 21), near_pos(1 << 21),
                         near_pos(1 << 20), near_pos(1 << 20), near_pos(1 << 20),
                         NRM_W'(near_pos(23170)), NRM_W'(near_pos(23170)),
                         NRM_W'(near_pos(23170)), COL_W'($urandom));
        end
        h.cr = COL_W'($urandom);
        h.cg = COL_W'($urandom);
        h.cb = COL_W'($urandom);
        return h;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) pending_hits.push_back(random_hit());
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // reset camera at the origin: directed corners
        idle_on = 0;
        pending_hits.push_back(make_hit(32'h0001_0000, 0, 32'h0002_0000, 32'h0001_0000, 0,
                                        32'h0002_0000, 0, 0, 16'h7fff, 16'hffff));
        pending_hits.push_back(make_hit(0, 0, 32'h0004_0000, 0, 0, 0,
                                        0, 0, 16'h7fff, 16'hffff));
        pending_hits.push_back(make_hit(0, 0, 32'h0004_0000, 0, 0, 32'h0001_0000,
                                        0, 0, 16'h7fff, 16'h8000));
        pending_hits.push_back(make_hit(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
        pending_hits.push_back(make_hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        16'h8000, 16'h8000, 16'h8000, 16'h0000));
        pending_hits.push_back(make_hit(32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                                        32'hffff_0000, 32'hfffe_0000, 32'h0001_0000,
                                        16'h8000, 16'h7fff, 16'h0000, 16'hffff));
        pending_hits.push_back(make_hit(1, 0, 0, 0, 0, 0, 16'h7fff, 0, 0, 16'hffff));
        pending_hits.push_back(make_hit(32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0,
                                        16'h8000, 16'h8000, 0, 16'h1234));
        pending_hits.push_back(make_hit(32'h0000_8000, 0, 32'h0001_0000, 32'hffff_8000, 0, 0,
                                        0, 0, 16'h7fff, 16'hffff));
        pending_hits.push_back(make_hit(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0,
                                        16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
        run_random(20);

        idle_on = 1;
        set_camera(0, 0, 32'h0008_0000);
        write_reg(CFG_SPARE, 32'h1234_5678);
        pending_hits.push_back(make_hit(0, 0, 32'h0004_0000, 0, 0, 32'h0008_0000,
                                        0, 0, 16'h7fff, 16'hffff));
        pending_hits.push_back(make_hit(0, 0, 32'h0008_0000, 0, 0, 0,
                                        0, 0, 16'h7fff, 16'hffff));
        run_random(100);

        set_camera(64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff);
        run_random(60);

        set_camera(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        run_random(60);

        idle_on = 0;
        set_camera(32'h0003_0000, -64'sh0002_0000, 32'h0010_0000);
        @(posedge i_clk);
        long_hold_req = 1;
        run_random(120);

        idle_on = 1;
        set_camera(-64'sh0005_0000, 32'h0001_8000, 32'h0004_0000);
        run_random(150);

        $display("%0d items accepted, %0d results checked, %0d with a specular highlight",
                 accepted, results, spec_hits);
        $display("camera settings covered origin, both extremes and near-scene positions");
        if (mismatches == 0 && expected_shades.size() == 0) begin
            $display("phong_point_light_shading_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_shades.size());
            $display("phong_point_light_shading_unit verification failed");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("timeout with %0d results outstanding", expected_shades.size());
        $display("phong_point_light_shading_unit verification failed");
        $finish;
    end

endmodule

### filelist.f
sv/ppls_pkg.sv
sv/ppls_front.sv
sv/ppls_queue.sv
sv/ppls_unit.sv
sv/ppls_back.sv
sv/phong_point_light_shading_unit.sv
dv/phong_point_light_shading_unit_tb.sv
